@@ src/mts_pkg.sv @@
// Package for the minimum-tracking stack: request codes, status codes,
// controller state type and the command/status bundles between the modules.
// No dependencies.
package mts_pkg;

	// Default number of entries held by the stack.
	localparam int unsigned MTS_DEPTH_DEF = 64;

	// Width of one stored value.
	localparam int unsigned MTS_DW = 32;

	// Request action codes. Any other code is a query.
	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_POP   = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;

	// Controller states.
	typedef enum logic {
		S_IDLE,
		S_FILL
	} mts_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic step;   // execute the accepted request
		logic fill;   // reload the cached tops after a pop
	} mts_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;  // stack holds no values
	} mts_stat_t;

endpackage

@@ src/mts_ctrl.sv @@
// Controller for the minimum-tracking stack: request acceptance, the pop
// refill cycle and the result strobe.
// Depends on mts_pkg.
module mts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        action,
	input  mts_pkg::mts_stat_t stat,
	output mts_pkg::mts_cmd_t  cmd,
	output logic              busy,
	output logic              done
);
	import mts_pkg::*;

	mts_state_t state_q;
	mts_state_t state_d;
	logic       done_q;
	logic       done_d;
	logic       pop_ok;

	// A pop that removes a value needs the refill cycle.
	assign pop_ok = (action == ACT_POP) && !stat.empty;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start && pop_ok) begin
					state_d = S_FILL;
				end
			end
			S_FILL: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		cmd.step = 1'b0;
		cmd.fill = 1'b0;
		busy     = 1'b0;
		done_d   = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.step = start;
				done_d   = start && !pop_ok;
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				busy     = 1'b1;
				done_d   = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// State and strobe registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign done = done_q;

endmodule

@@ src/mts_datapath.sv @@
// Datapath for the minimum-tracking stack: value and minimum memories,
// their counts, the cached top entries and the result status.
// Depends on mts_pkg.
module mts_datapath #(
	parameter int unsigned STACK_DEPTH = mts_pkg::MTS_DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mts_pkg::mts_cmd_t                      cmd,
	input  logic [1:0]                             action,
	input  logic signed [mts_pkg::MTS_DW-1:0]      value,
	output mts_pkg::mts_stat_t                     stat,
	output logic signed [mts_pkg::MTS_DW-1:0]      top_value,
	output logic signed [mts_pkg::MTS_DW-1:0]      min_value,
	output logic [$clog2(STACK_DEPTH+1)-1:0]       depth,
	output logic                                   is_empty,
	output logic [1:0]                             status
);
	import mts_pkg::*;

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned CW = $clog2(STACK_DEPTH+1);

	logic [MTS_DW-1:0]        val_mem [STACK_DEPTH];
	logic [MTS_DW-1:0]        min_mem [STACK_DEPTH];
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            mcount_q;
	logic signed [MTS_DW-1:0] top_q;
	logic signed [MTS_DW-1:0] min_q;
	logic [1:0]               status_q;
	logic [MTS_DW-1:0]        rd_val_q;
	logic [MTS_DW-1:0]        rd_min_q;

	logic          empty;
	logic          full;
	logic          min_empty;
	logic          do_push;
	logic          do_pop;
	logic          min_push;
	logic          min_pop;
	logic [CW-1:0] cnt_m2;
	logic [CW-1:0] mcnt_new;
	logic [CW-1:0] mcnt_new_m1;

	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(STACK_DEPTH));
	assign min_empty = (mcount_q == '0);

	// Decode of the accepted request.
	assign do_push  = cmd.step && (action == ACT_PUSH) && !full;
	assign do_pop   = cmd.step && (action == ACT_POP) && !empty;
	assign min_push = do_push && (min_empty || (value <= min_q));
	// The popped value is the cached top.
	assign min_pop  = do_pop && !min_empty && (top_q == min_q);

	// Read addresses of the entries that become the new tops after a pop.
	assign cnt_m2      = count_q - CW'(2);
	assign mcnt_new    = min_pop ? (mcount_q - CW'(1)) : mcount_q;
	assign mcnt_new_m1 = mcnt_new - CW'(1);

	// Value memory: write on push, synchronous read on every request.
	always_ff @(posedge clk) begin
		if (do_push) begin
			val_mem[count_q[AW-1:0]] <= value;
		end
		if (cmd.step) begin
			rd_val_q <= val_mem[cnt_m2[AW-1:0]];
		end
	end

	// Minimum memory: write when a new minimum is pushed.
	always_ff @(posedge clk) begin
		if (min_push) begin
			min_mem[mcount_q[AW-1:0]] <= value;
		end
		if (cmd.step) begin
			rd_min_q <= min_mem[mcnt_new_m1[AW-1:0]];
		end
	end

	// Counts, cached tops and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			mcount_q <= '0;
			top_q    <= '0;
			min_q    <= '0;
			status_q <= ST_OK;
		end else if (cmd.step) begin
			status_q <= ST_OK;
			case (action)
				ACT_PUSH: begin
					if (full) begin
						status_q <= ST_OVERFLOW;
					end else begin
						count_q <= count_q + CW'(1);
						top_q   <= value;
						if (min_push) begin
							mcount_q <= mcount_q + CW'(1);
							min_q    <= value;
						end
					end
				end
				ACT_POP: begin
					if (empty) begin
						status_q <= ST_UNDERFLOW;
					end else begin
						count_q  <= count_q - CW'(1);
						mcount_q <= mcnt_new;
					end
				end
				default: begin
					status_q <= ST_OK;
				end
			endcase
		end else if (cmd.fill) begin
			// Load the new tops from memory; an empty stack reads as zero.
			top_q <= empty ? '0 : $signed(rd_val_q);
			min_q <= (empty || min_empty) ? '0 : $signed(rd_min_q);
		end
	end

	assign stat.empty = empty;
	assign top_value  = top_q;
	assign min_value  = min_q;
	assign depth      = count_q;
	assign is_empty   = empty;
	assign status     = status_q;

endmodule

@@ src/min_tracking_stack.sv @@
// Top level of the minimum-tracking stack: controller plus datapath.
// Depends on mts_pkg, mts_ctrl and mts_datapath.
//
// A bounded LIFO of signed 32-bit values that also reports the smallest
// value held. A request is taken when start is high and busy is low; its
// result (top, minimum, depth, empty flag, status) appears for exactly one
// cycle with done high, the cycle after the request for push and query,
// and after the refill state for a pop that removes a value. Push and
// query sustain one request per cycle; such a pop holds busy high in the
// refill state, as the new top and minimum come from a synchronous read of
// the value and minimum memories. The receiver cannot stall results. Pop on
// an empty stack reports underflow, push on a full stack reports overflow;
// neither changes the contents. Top and minimum read as zero when empty.
module min_tracking_stack #(
	parameter int unsigned STACK_DEPTH = mts_pkg::MTS_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        action,
	input  logic signed [mts_pkg::MTS_DW-1:0] value,
	output logic                              done,
	output logic signed [mts_pkg::MTS_DW-1:0] top_value,
	output logic signed [mts_pkg::MTS_DW-1:0] min_value,
	output logic [$clog2(STACK_DEPTH+1)-1:0]  depth,
	output logic                              is_empty,
	output logic [1:0]                        status
);
	import mts_pkg::*;

	mts_cmd_t  cmd;
	mts_stat_t stat;

	// Sequencing of requests and results.
	mts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Storage and arithmetic.
	mts_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.action    (action),
		.value     (value),
		.stat      (stat),
		.top_value (top_value),
		.min_value (min_value),
		.depth     (depth),
		.is_empty  (is_empty),
		.status    (status)
	);

endmodule

@@ src/mts_checker.sv @@
// Port-level checks for the minimum-tracking stack, bound to the top level.
// Depends on mts_pkg and min_tracking_stack.
module mts_checker #(
	parameter int unsigned STACK_DEPTH = mts_pkg::MTS_DEPTH_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic [1:0]                        action,
	input logic                              done,
	input logic signed [mts_pkg::MTS_DW-1:0] top_value,
	input logic signed [mts_pkg::MTS_DW-1:0] min_value,
	input logic [$clog2(STACK_DEPTH+1)-1:0]  depth,
	input logic                              is_empty,
	input logic [1:0]                        status
);
	import mts_pkg::*;

	// A push or query request yields its result in the next cycle.
	a_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (action != ACT_POP) |=> done && !busy)
		else $error("push or query result missing");

	// The refill cycle always ends with a result and frees the block.
	a_fill_result: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("pop result missing after refill");

	// An empty stack shows depth zero and zero top and minimum.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_empty |-> (depth == '0) && (top_value == '0) && (min_value == '0))
		else $error("empty stack shows nonzero fields");

	// The minimum never exceeds the top value.
	a_min_le_top: assert property (@(posedge clk) disable iff (!arst_n)
		done && !is_empty |-> (min_value <= top_value))
		else $error("minimum above top value");

	// Error status only at the matching fill level.
	a_status_depth: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((status != ST_OVERFLOW) || (depth == STACK_DEPTH))
			&& ((status != ST_UNDERFLOW) || is_empty))
		else $error("status does not match depth");

endmodule

bind min_tracking_stack mts_checker #(.STACK_DEPTH(STACK_DEPTH)) u_mts_checker (.*);

@@ test/min_tracking_stack_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for min_tracking_stack: a queue-fed request driver, a result monitor
// and a shadow stack that predicts top, minimum, depth, empty flag and status.
// Depends on mts_pkg and min_tracking_stack.
module min_tracking_stack_test;
	import mts_pkg::*;

	localparam int unsigned DEPTH = MTS_DEPTH_DEF;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int MAX_GAP = 30;
	localparam int PHASE_ITEMS = 300;
	// The unused action code behaves like a query.
	localparam logic [1:0] ACT_SPARE = 2'd3;

	typedef struct {
		logic [1:0]               action;
		logic signed [MTS_DW-1:0] value;
		int                       gap;
	} request_t;

	typedef struct {
		logic signed [MTS_DW-1:0] top;
		logic signed [MTS_DW-1:0] minimum;
		logic [CW-1:0]            depth;
		logic                     is_empty;
		logic [1:0]               status;
	} stack_view_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic [1:0]               action = ACT_QUERY;
	logic signed [MTS_DW-1:0] value = '0;
	logic                     busy;
	logic                     done;
	logic signed [MTS_DW-1:0] top_value;
	logic signed [MTS_DW-1:0] min_value;
	logic [CW-1:0]            depth;
	logic                     is_empty;
	logic [1:0]               status;

	// Shadow copy of the two stores and their fill levels.
	logic signed [MTS_DW-1:0] shadow_values [DEPTH];
	logic signed [MTS_DW-1:0] shadow_minima [DEPTH];
	int unsigned              value_level = 0;
	int unsigned              minimum_level = 0;

	request_t    pending_requests[$];
	stack_view_t expected_views[$];
	request_t    next_request;
	stack_view_t wanted_view;
	int          idle_left = 0;
	int          current_gap = 0;
	int          error_count = 0;

	min_tracking_stack i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.action    (action),
		.value     (value),
		.done      (done),
		.top_value (top_value),
		.min_value (min_value),
		.depth     (depth),
		.is_empty  (is_empty),
		.status    (status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one request to the shadow stack and return the view it leaves behind.
	function automatic stack_view_t apply_request(logic [1:0] act, logic signed [MTS_DW-1:0] val);
		stack_view_t view;
		view.status = ST_OK;
		if (act == ACT_PUSH) begin
			if (value_level >= DEPTH) begin
				view.status = ST_OVERFLOW;
			end else begin
				shadow_values[value_level] = val;
				value_level++;
				// Ties go on the minimum stack too, so duplicates pop correctly.
				if (minimum_level == 0 || val <= shadow_minima[minimum_level - 1]) begin
					if (minimum_level < DEPTH) begin
						shadow_minima[minimum_level] = val;
						minimum_level++;
					end
				end
			end
		end else if (act == ACT_POP) begin
			if (value_level == 0) begin
				view.status = ST_UNDERFLOW;
			end else begin
				if (minimum_level > 0 &&
						shadow_values[value_level - 1] == shadow_minima[minimum_level - 1]) begin
					minimum_level--;
				end
				value_level--;
			end
		end
		view.top = (value_level > 0) ? shadow_values[value_level - 1] : '0;
		view.minimum = (value_level > 0 && minimum_level > 0) ?
			shadow_minima[minimum_level - 1] : '0;
		view.depth = value_level[CW-1:0];
		view.is_empty = (value_level == 0);
		return view;
	endfunction

	function automatic void compare_field(string name, logic [MTS_DW-1:0] want,
			logic [MTS_DW-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			error_count++;
		end
	endfunction

	// Idle cycles after a request: each further cycle is idle with the given percentage.
	function automatic int draw_gap(int pct);
		int g = 0;
		while (g < MAX_GAP && $urandom_range(99) < pct) g++;
		return g;
	endfunction

	// Values cluster in a small range now and then so that equal minima come up often.
	function automatic logic signed [MTS_DW-1:0] draw_value();
		case ($urandom_range(3))
			0: return $signed($urandom_range(8)) - 4;
			1: begin
				case ($urandom_range(3))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return '0;
					default: return -1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic add_request(logic [1:0] act, logic signed [MTS_DW-1:0] val, int gap);
		request_t req;
		req.action = act;
		req.value = val;
		req.gap = gap;
		pending_requests.push_back(req);
	endtask

	// Driver: a request is taken when start is high and busy is low, then the next one
	// is presented after its idle gap. While busy, the current request is held.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_views.push_back(apply_request(action, value));
				idle_left = current_gap;
			end
			if (!start || !busy) begin
				if (idle_left > 0) begin
					idle_left--;
					start <= 1'b0;
					action <= 2'($urandom_range(3));
					value <= $urandom;
				end else if (pending_requests.size() > 0) begin
					next_request = pending_requests.pop_front();
					current_gap = next_request.gap;
					start <= 1'b1;
					action <= next_request.action;
					value <= next_request.value;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every result strobe is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_views.size() == 0) begin
				$display("%0t: result with no request waiting: top %h min %h depth %0d status %0d",
					$time, top_value, min_value, depth, status);
				error_count++;
			end else begin
				wanted_view = expected_views.pop_front();
				compare_field("top_value", wanted_view.top, top_value);
				compare_field("min_value", wanted_view.minimum, min_value);
				compare_field("depth", MTS_DW'(wanted_view.depth), MTS_DW'(depth));
				compare_field("is_empty", MTS_DW'(wanted_view.is_empty), MTS_DW'(is_empty));
				compare_field("status", MTS_DW'(wanted_view.status), MTS_DW'(status));
			end
		end
	end

	initial begin
		int idle_pct [4];
		int made;
		int mode;
		int run;
		int push_limit;
		int roll;
		logic [1:0] act;

		idle_pct = '{0, 66, 0, 38};

		// Directed requests: empty-stack reads, underflow, the spare code, extremes,
		// equal minima and their removal.
		add_request(ACT_QUERY, 32'sd7, 0);
		add_request(ACT_POP, 32'sd0, 0);
		add_request(ACT_SPARE, -1, 0);
		add_request(ACT_PUSH, 32'sh7fffffff, 0);
		add_request(ACT_PUSH, 32'sh80000000, 0);
		add_request(ACT_PUSH, 32'sh80000000, 0);
		add_request(ACT_PUSH, 32'sd0, 0);
		add_request(ACT_PUSH, -1, 0);
		add_request(ACT_QUERY, 32'sh55555555, 0);
		add_request(ACT_POP, 32'shaaaaaaaa, 0);
		add_request(ACT_POP, 32'sd0, 0);
		add_request(ACT_POP, 32'sd0, 0);
		add_request(ACT_QUERY, 32'sd0, 0);
		add_request(ACT_POP, 32'sd0, 0);
		add_request(ACT_POP, 32'sd0, 0);
		add_request(ACT_POP, 32'sd0, 0);
		add_request(ACT_PUSH, 32'sd5, 0);
		add_request(ACT_PUSH, 32'sd5, 0);
		add_request(ACT_PUSH, 32'sd3, 0);
		add_request(ACT_PUSH, 32'sd3, 0);
		add_request(ACT_POP, 32'sd0, 0);
		add_request(ACT_POP, 32'sd0, 0);
		add_request(ACT_POP, 32'sd0, 0);
		add_request(ACT_POP, 32'sd0, 0);

		// Random phases: runs that lean to push, to pop or neither, plus full fills
		// to overflow and full drains to underflow.
		for (int phase = 0; phase < 4; phase++) begin
			made = 0;
			while (made < PHASE_ITEMS) begin
				mode = $urandom_range(9);
				run = (mode >= 8) ? DEPTH + 6 : $urandom_range(20, 60);
				push_limit = (mode <= 2) ? 82 : (mode <= 4) ? 40 : 55;
				for (int k = 0; k < run; k++) begin
					roll = $urandom_range(99);
					if (mode == 8) act = ACT_PUSH;
					else if (mode == 9) act = ACT_POP;
					else if (roll < 3) act = ACT_SPARE;
					else if (roll < 10) act = ACT_QUERY;
					else if (roll < push_limit) act = ACT_PUSH;
					else act = ACT_POP;
					add_request(act, draw_value(), draw_gap(idle_pct[phase]));
				end
				made += run;
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || start || expected_views.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (error_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
